// ===== sv/ssrc_pkg.sv =====
// shared types, opcodes, register map and arithmetic helpers of the servo slew ramp controller
`timescale 1ns / 1ps
`default_nettype none
package ssrc_pkg;

  localparam int unsigned MaxDeg = 180;
  localparam logic [7:0] MaxDegVal = 8'(MaxDeg);
  localparam logic [11:0] LevelBase = 12'd500;
  // 2000/180 scaled by 2^16 and rounded up, exact after truncation for angles 0..255
  localparam logic [27:0] LevelRecip = 28'd728178;

  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [3:0] {
    OP_TICK       = 4'd0,
    OP_OPEN_VALUE = 4'd1,
    OP_OPEN_DEF   = 4'd2,
    OP_CLOSE      = 4'd3,
    OP_SHUT_OPEN  = 4'd4,
    OP_SHUT_CLOSE = 4'd5,
    OP_RAW_LEFT   = 4'd6,
    OP_RAW_SHUT   = 4'd7,
    OP_RAW_RIGHT  = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    REG_LEFT_CLOSED  = 3'd0,
    REG_RIGHT_CLOSED = 3'd1,
    REG_OPEN_AMOUNT  = 3'd2,
    REG_SHUT_OPEN    = 3'd3,
    REG_SHUT_CLOSED  = 3'd4,
    REG_DOOR_STEP    = 3'd5,
    REG_SHUT_STEP    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]        left_closed_angle;
    logic [7:0]        right_closed_angle;
    logic signed [8:0] open_amount;
    logic [7:0]        shutter_open_angle;
    logic [7:0]        shutter_closed_angle;
    logic [7:0]        door_step_ticks;
    logic [7:0]        shutter_step_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] left_angle;
    logic [7:0] right_angle;
    logic [7:0] shutter_angle;
    logic       doors_busy;
    logic       shutter_busy;
  } status_t;

  // clamp a signed sum to 0..180
  function automatic logic [7:0] clamp_deg(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > $signed(11'(MaxDeg))) begin
      r = MaxDegVal;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // clamp an unsigned register angle to 0..180
  function automatic logic [7:0] clamp_u8(input logic [7:0] v);
    return (v > MaxDegVal) ? MaxDegVal : v;
  endfunction

  // one degree toward target
  function automatic logic [7:0] toward(input logic [7:0] a, input logic [7:0] t);
    logic [7:0] r;
    if (a < t) begin
      r = a + 8'd1;
    end else if (a > t) begin
      r = a - 8'd1;
    end else begin
      r = a;
    end
    return r;
  endfunction

  // 500 + a*2000/180, truncated, by reciprocal multiply
  function automatic logic [11:0] level_of(input logic [7:0] a);
    logic [27:0] p;
    p = 28'(a) * LevelRecip;
    return LevelBase + p[27:16];
  endfunction

endpackage
`default_nettype wire

// ===== sv/ssrc_cfg.sv =====
// apb register file holding the controller settings
`timescale 1ns / 1ps
`default_nettype none
module ssrc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ssrc_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output ssrc_pkg::cfg_t                      cfg
);

  ssrc_pkg::cfg_t cfg_r;
  ssrc_pkg::reg_idx_t idx;
  logic wr_en;

  assign idx   = ssrc_pkg::reg_idx_t'(paddr[ssrc_pkg::CfgAddrW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_closed_angle    <= 8'd90;
      cfg_r.right_closed_angle   <= 8'd90;
      cfg_r.open_amount          <= 9'sd60;
      cfg_r.shutter_open_angle   <= 8'd100;
      cfg_r.shutter_closed_angle <= 8'd10;
      cfg_r.door_step_ticks      <= 8'd8;
      cfg_r.shutter_step_ticks   <= 8'd6;
    end else if (wr_en) begin
      case (idx)
        ssrc_pkg::REG_LEFT_CLOSED:  cfg_r.left_closed_angle    <= pwdata[7:0];
        ssrc_pkg::REG_RIGHT_CLOSED: cfg_r.right_closed_angle   <= pwdata[7:0];
        ssrc_pkg::REG_OPEN_AMOUNT:  cfg_r.open_amount          <= $signed(pwdata[8:0]);
        ssrc_pkg::REG_SHUT_OPEN:    cfg_r.shutter_open_angle   <= pwdata[7:0];
        ssrc_pkg::REG_SHUT_CLOSED:  cfg_r.shutter_closed_angle <= pwdata[7:0];
        ssrc_pkg::REG_DOOR_STEP:    cfg_r.door_step_ticks      <= pwdata[7:0];
        ssrc_pkg::REG_SHUT_STEP:    cfg_r.shutter_step_ticks   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (idx)
      ssrc_pkg::REG_LEFT_CLOSED:  prdata = 32'(cfg_r.left_closed_angle);
      ssrc_pkg::REG_RIGHT_CLOSED: prdata = 32'(cfg_r.right_closed_angle);
      ssrc_pkg::REG_OPEN_AMOUNT:  prdata = 32'(unsigned'(cfg_r.open_amount));
      ssrc_pkg::REG_SHUT_OPEN:    prdata = 32'(cfg_r.shutter_open_angle);
      ssrc_pkg::REG_SHUT_CLOSED:  prdata = 32'(cfg_r.shutter_closed_angle);
      ssrc_pkg::REG_DOOR_STEP:    prdata = 32'(cfg_r.door_step_ticks);
      ssrc_pkg::REG_SHUT_STEP:    prdata = 32'(cfg_r.shutter_step_ticks);
      default:                    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/ssrc_core.sv =====
// angle and target state with command decode and tick pacing
`timescale 1ns / 1ps
`default_nettype none
module ssrc_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [3:0]        opcode,
  input  wire logic signed [9:0] value,
  input  wire ssrc_pkg::cfg_t    cfg,
  output ssrc_pkg::status_t      status
);

  logic [7:0] left_angle_r, right_angle_r, shutter_angle_r;
  logic [7:0] left_target_r, right_target_r, shutter_target_r;
  logic [7:0] door_cnt_r, shutter_cnt_r;

  logic [7:0] left_angle_nxt, right_angle_nxt, shutter_angle_nxt;
  logic [7:0] left_target_nxt, right_target_nxt, shutter_target_nxt;
  logic [7:0] door_cnt_nxt, shutter_cnt_nxt;

  logic signed [10:0] amount;
  logic [7:0] left_closed, right_closed;
  logic [7:0] door_n, shutter_n, door_inc, shutter_inc;
  logic doors_busy_now, shutter_busy_now;

  assign left_closed  = ssrc_pkg::clamp_u8(cfg.left_closed_angle);
  assign right_closed = ssrc_pkg::clamp_u8(cfg.right_closed_angle);
  assign door_n       = (cfg.door_step_ticks == 8'd0) ? 8'd1 : cfg.door_step_ticks;
  assign shutter_n    = (cfg.shutter_step_ticks == 8'd0) ? 8'd1 : cfg.shutter_step_ticks;
  assign door_inc     = door_cnt_r + 8'd1;
  assign shutter_inc  = shutter_cnt_r + 8'd1;
  assign doors_busy_now   = (left_angle_r != left_target_r) || (right_angle_r != right_target_r);
  assign shutter_busy_now = shutter_angle_r != shutter_target_r;

  // amount for the open commands, by value or by the configured default
  assign amount = (ssrc_pkg::op_t'(opcode) == ssrc_pkg::OP_OPEN_DEF) ?
                  11'(cfg.open_amount) : 11'(value);

  always_comb begin
    left_angle_nxt     = left_angle_r;
    right_angle_nxt    = right_angle_r;
    shutter_angle_nxt  = shutter_angle_r;
    left_target_nxt    = left_target_r;
    right_target_nxt   = right_target_r;
    shutter_target_nxt = shutter_target_r;
    door_cnt_nxt       = door_cnt_r;
    shutter_cnt_nxt    = shutter_cnt_r;
    case (ssrc_pkg::op_t'(opcode))
      ssrc_pkg::OP_TICK: begin
        if (doors_busy_now) begin
          if (door_inc >= door_n) begin
            left_angle_nxt  = ssrc_pkg::toward(left_angle_r, left_target_r);
            right_angle_nxt = ssrc_pkg::toward(right_angle_r, right_target_r);
            door_cnt_nxt    = 8'd0;
          end else begin
            door_cnt_nxt = door_inc;
          end
        end else begin
          door_cnt_nxt = 8'd0;
        end
        if (shutter_busy_now) begin
          if (shutter_inc >= shutter_n) begin
            shutter_angle_nxt = ssrc_pkg::toward(shutter_angle_r, shutter_target_r);
            shutter_cnt_nxt   = 8'd0;
          end else begin
            shutter_cnt_nxt = shutter_inc;
          end
        end else begin
          shutter_cnt_nxt = 8'd0;
        end
      end
      ssrc_pkg::OP_OPEN_VALUE, ssrc_pkg::OP_OPEN_DEF: begin
        left_target_nxt  = ssrc_pkg::clamp_deg(11'(left_closed) + amount);
        right_target_nxt = ssrc_pkg::clamp_deg(11'(right_closed) - amount);
      end
      ssrc_pkg::OP_CLOSE: begin
        left_target_nxt  = left_closed;
        right_target_nxt = right_closed;
      end
      ssrc_pkg::OP_SHUT_OPEN:  shutter_target_nxt = ssrc_pkg::clamp_u8(cfg.shutter_open_angle);
      ssrc_pkg::OP_SHUT_CLOSE: shutter_target_nxt = ssrc_pkg::clamp_u8(cfg.shutter_closed_angle);
      ssrc_pkg::OP_RAW_LEFT: begin
        left_target_nxt  = ssrc_pkg::clamp_deg(11'(value));
        right_target_nxt = right_angle_r;
      end
      ssrc_pkg::OP_RAW_SHUT: shutter_target_nxt = ssrc_pkg::clamp_deg(11'(value));
      ssrc_pkg::OP_RAW_RIGHT: begin
        right_target_nxt = ssrc_pkg::clamp_deg(11'(value));
        left_target_nxt  = left_angle_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_angle_r     <= 8'd90;
      right_angle_r    <= 8'd90;
      shutter_angle_r  <= 8'd10;
      left_target_r    <= 8'd90;
      right_target_r   <= 8'd90;
      shutter_target_r <= 8'd10;
      door_cnt_r       <= 8'd0;
      shutter_cnt_r    <= 8'd0;
    end else if (accept) begin
      left_angle_r     <= left_angle_nxt;
      right_angle_r    <= right_angle_nxt;
      shutter_angle_r  <= shutter_angle_nxt;
      left_target_r    <= left_target_nxt;
      right_target_r   <= right_target_nxt;
      shutter_target_r <= shutter_target_nxt;
      door_cnt_r       <= door_cnt_nxt;
      shutter_cnt_r    <= shutter_cnt_nxt;
    end
  end

  always_comb begin
    status.left_angle    = left_angle_nxt;
    status.right_angle   = right_angle_nxt;
    status.shutter_angle = shutter_angle_nxt;
    status.doors_busy    = (left_angle_nxt != left_target_nxt) ||
                           (right_angle_nxt != right_target_nxt);
    status.shutter_busy  = shutter_angle_nxt != shutter_target_nxt;
  end

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_angle_r <= ssrc_pkg::MaxDegVal) else $error("left angle out of range");
  a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
    right_angle_r <= ssrc_pkg::MaxDegVal) else $error("right angle out of range");
  a_shut_range: assert property (@(posedge clk) disable iff (!rst_n)
    shutter_angle_r <= ssrc_pkg::MaxDegVal) else $error("shutter angle out of range");
  a_move_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (ssrc_pkg::op_t'(opcode) != ssrc_pkg::OP_TICK) |=>
      $stable(left_angle_r) && $stable(right_angle_r) && $stable(shutter_angle_r))
    else $error("angle moved on a command other than tick");

endmodule
`default_nettype wire

// ===== sv/servo_slew_ramp_controller.sv =====
// top level of the three-channel servo slew ramp controller
`timescale 1ns / 1ps
`default_nettype none
// Three-servo slew ramp controller for a paired left/right door and a shutter. Every input
// transaction (a tick or a command) produces exactly one output transaction holding the PWM
// compare levels of all three servos after the update, plus door and shutter busy flags.
// Commands replace the targets at once; on each tick a busy group counts ticks and steps its
// angles one degree toward target every step_ticks ticks (zero counts as one). The block takes
// one transaction per cycle unless out_tready stalls: the state update and level multiply sit
// between the state and output registers, so throughput is one item per clock and out_tvalid
// rises in the cycle after accept. The output register lets a new input be accepted in the
// same cycle the waiting result is taken. The user writes settings over the apb port only
// while the stream is idle; the block does not enforce it. No clearing pass after reset.
module servo_slew_ramp_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [3:0] opcode, [13:4] value, [15:14] zero
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [11:0] left_level, [23:12] right_level,
                                       // [35:24] shutter_level, [36] doors_busy,
                                       // [37] shutter_busy, [39:38] zero
  // configuration
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ssrc_pkg::CfgAddrW-1:0] cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic      [31:0]                   cfg_prdata,
  output logic                               cfg_pready
);

  ssrc_pkg::cfg_t    cfg;
  ssrc_pkg::status_t status;

  logic        in_acc;
  logic        out_valid_r, out_valid_nxt;
  logic [11:0] left_level_r, right_level_r, shutter_level_r;
  logic        doors_busy_r, shutter_busy_r;

  assign cfg_pready = 1'b1;

  // result register frees up when empty or being taken this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  ssrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  ssrc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .opcode (in_tdata[3:0]),
    .value  ($signed(in_tdata[13:4])),
    .cfg    (cfg),
    .status (status)
  );

  assign out_valid_nxt = in_acc || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_level_r    <= ssrc_pkg::level_of(status.left_angle);
      right_level_r   <= ssrc_pkg::level_of(status.right_angle);
      shutter_level_r <= ssrc_pkg::level_of(status.shutter_angle);
      doors_busy_r    <= status.doors_busy;
      shutter_busy_r  <= status.shutter_busy;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, shutter_busy_r, doors_busy_r,
                       shutter_level_r, right_level_r, left_level_r};

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r) else $error("accepted transaction produced no result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_acc) else $error("result overwritten while stalled");
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> left_level_r <= 12'd2500 && right_level_r <= 12'd2500 &&
                    shutter_level_r <= 12'd2500) else $error("level out of range");

endmodule
`default_nettype wire
